// File: src/hbps_pkg.sv
package hbps_pkg;

  localparam int BIN_COUNT = 256;
  localparam int WINDOW    = 5;

  typedef enum logic [1:0] {
    OP_ACCUM   = 2'd0,
    OP_SHIFTS  = 2'd1,
    OP_STRETCH = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_RED   = 2'd1,
    REG_GREEN = 2'd2,
    REG_BLUE  = 2'd3
  } reg_idx_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_SHIFT = 1'b1;

endpackage

// File: src/hbps_div.sv
module hbps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] q_r, q_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;
  logic [17:0] shifted;

  assign shifted = {rem_r[16:0], q_r[31]};
  assign trial   = shifted - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start && !busy_r) d_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: src/histogram_black_point_stretch_core.sv
// Black-point histogram stretch, one command per start beat; busy is high from the accepting
// edge until the command has finished. Ops 1 and 2 end in a result beat on out_valid in the
// first cycle with busy low, for one cycle only: the receiver cannot stall it; ops 0 and 3
// give no beat. Op 0 bins a pixel with a read, wait and write step per channel; op 3 clears
// the histograms; op 1 in absolute mode goes straight to its result, and in relative mode
// smooths each histogram with a WINDOW-bin sum inside the window range and a zero at each
// edge bin, then walks down from the peak bin and stores the shift; op 2 runs the channels
// one after another through a shared 32-step restoring divider. After reset a clearing pass
// over all 3*BIN_COUNT histogram entries runs with busy high.
module histogram_black_point_stretch_core #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_red_in,
  input  logic [15:0] in_green_in,
  input  logic [15:0] in_blue_in,
  output logic        out_valid,
  output logic        out_kind,
  output logic [15:0] out_red_out,
  output logic [15:0] out_green_out,
  output logic [15:0] out_blue_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int BIN_COUNT = hbps_pkg::BIN_COUNT;
  localparam int WINDOW    = hbps_pkg::WINDOW;
  localparam int BW      = $clog2(BIN_COUNT);
  localparam int DEPTH   = 3 * BIN_COUNT;
  localparam int AW      = $clog2(DEPTH);
  localparam int HALF    = WINDOW / 2;
  localparam int SUM_W   = COUNT_BITS + $clog2(WINDOW + 1);
  localparam int PROD_W  = SUM_W + 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ACC_RD = 13'b0000000000100,
    S_ACC_WT = 13'b0000000001000,
    S_ACC_WR = 13'b0000000010000,
    S_SM_RD  = 13'b0000000100000,
    S_SM_ACC = 13'b0000001000000,
    S_SR_RD  = 13'b0000010000000,
    S_SR_CMP = 13'b0000100000000,
    S_SH_END = 13'b0001000000000,
    S_DV_GO  = 13'b0010000000000,
    S_DV_WT  = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] hist_mem [DEPTH];
  logic [SUM_W-1:0]      smooth_mem [DEPTH];
  logic [COUNT_BITS-1:0] hist_q;
  logic [SUM_W-1:0]      smooth_q;
  logic [AW-1:0]         h_raddr, h_waddr, s_raddr, s_waddr;
  logic                  h_we, s_we;
  logic [COUNT_BITS-1:0] h_wdata;
  logic [SUM_W-1:0]      s_wdata;

  logic                  mode_r;
  logic [15:0]           level_r [3];
  logic [15:0]           shift_r [3];
  logic [15:0]           pix_r [3];
  logic [15:0]           res_r [3];
  logic [1:0]            ch_r, ch_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [BW:0]           bin_r, bin_nxt;
  logic [BW:0]           peak_at_r, peak_at_nxt;
  logic [SUM_W-1:0]      peak_r, peak_nxt;
  logic [SUM_W-1:0]      acc_r, acc_nxt;
  logic [$clog2(WINDOW+1)-1:0] k_r, k_nxt;
  logic [PROD_W-1:0]     lim_r;
  logic                  found_r, found_nxt;
  logic                  ov_nxt;
  logic                  ok_r, ok_nxt;
  logic                  out_valid_r;
  logic                  kind_r;
  logic [15:0]           cur_s;
  logic [16:0]           d_v, d_s;
  logic [BW-1:0]         pbin;
  logic                  dv_start;
  logic                  dv_done;
  logic [31:0]           dv_q;
  logic [BW+16:0]        shv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      for (int c = 0; c < 3; c++) level_r[c] <= '0;
    end else if (cfg_valid) begin
      unique case (hbps_pkg::reg_idx_t'(cfg_index))
        hbps_pkg::REG_MODE:  mode_r <= cfg_data[0];
        hbps_pkg::REG_RED:   level_r[0] <= cfg_data;
        hbps_pkg::REG_GREEN: level_r[1] <= cfg_data;
        hbps_pkg::REG_BLUE:  level_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_waddr] <= h_wdata;
    hist_q <= hist_mem[h_raddr];
    if (s_we) smooth_mem[s_waddr] <= s_wdata;
    smooth_q <= smooth_mem[s_raddr];
  end

  assign cur_s = mode_r ? shift_r[ch_r] : level_r[ch_r];
  assign d_v   = {1'b0, pix_r[ch_r]};
  assign d_s   = {1'b0, cur_s};
  assign pbin  = pix_r[ch_r][15 -: BW];

  assign dv_start = (state_r == S_DV_GO);

  hbps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend ({d_v[15:0] - d_s[15:0], 16'd0}),
    .divisor  (17'h10000 - d_s),
    .done     (dv_done),
    .quotient (dv_q)
  );

  function automatic logic [AW-1:0] addr(input logic [1:0] c, input logic [BW:0] b);
    logic [AW:0] a;
    a = (AW+1)'(c) * (AW+1)'(BIN_COUNT) + (AW+1)'(b);
    return a[AW-1:0];
  endfunction

  always_comb begin
    state_nxt   = state_r;
    ch_nxt      = ch_r;
    idx_nxt     = idx_r;
    bin_nxt     = bin_r;
    peak_nxt    = peak_r;
    peak_at_nxt = peak_at_r;
    acc_nxt     = acc_r;
    k_nxt       = k_r;
    found_nxt   = found_r;
    ov_nxt      = 1'b0;
    ok_nxt      = ok_r;
    h_we        = 1'b0;
    h_waddr     = idx_r;
    h_wdata     = '0;
    h_raddr     = addr(ch_r, {1'b0, pbin});
    s_we        = 1'b0;
    s_waddr     = addr(ch_r, bin_r);
    s_wdata     = acc_r;
    s_raddr     = addr(ch_r, bin_r);
    unique case (state_r)
      S_CLEAR: begin
        h_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        ch_nxt = 2'd0;
        if (start) begin
          unique case (hbps_pkg::op_t'(in_op))
            hbps_pkg::OP_ACCUM:   state_nxt = S_ACC_RD;
            hbps_pkg::OP_CLEAR: begin
              idx_nxt = '0;
              state_nxt = S_CLEAR;
            end
            hbps_pkg::OP_STRETCH: state_nxt = S_DV_GO;
            hbps_pkg::OP_SHIFTS: begin
              bin_nxt = '0;
              k_nxt = '0;
              acc_nxt = '0;
              peak_nxt = '0;
              peak_at_nxt = '0;
              state_nxt = mode_r ? S_SM_RD : S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_ACC_RD: state_nxt = S_ACC_WT;
      S_ACC_WT: state_nxt = S_ACC_WR;
      S_ACC_WR: begin
        h_we = 1'b1;
        h_waddr = addr(ch_r, {1'b0, pbin});
        h_wdata = (hist_q == CNT_MAX) ? hist_q : hist_q + 1'b1;
        if (ch_r == 2'd2) state_nxt = S_IDLE;
        else begin
          ch_nxt = ch_r + 1'b1;
          state_nxt = S_ACC_RD;
        end
      end
      S_SM_RD: begin
        h_raddr = addr(ch_r, (BW+1)'(bin_r + (BW+1)'(k_r) - (BW+1)'(HALF)));
        state_nxt = S_SM_ACC;
        if ((bin_r < (BW+1)'(HALF)) || (bin_r >= (BW+1)'(BIN_COUNT - HALF))) begin
          s_we = 1'b1;
          s_wdata = '0;
          state_nxt = S_SM_RD;
          if (bin_r == (BW+1)'(BIN_COUNT - 1)) begin
            bin_nxt = (peak_at_r == '0) ? '0 : peak_at_r - 1'b1;
            found_nxt = 1'b0;
            ok_nxt = (peak_at_r != '0);
            state_nxt = S_SR_RD;
          end else bin_nxt = bin_r + 1'b1;
        end
      end
      S_SM_ACC: begin
        acc_nxt = acc_r + SUM_W'(hist_q);
        if (k_r == ($bits(k_r))'(WINDOW - 1)) begin
          s_we = 1'b1;
          s_wdata = acc_r + SUM_W'(hist_q);
          if (acc_nxt > peak_r) begin
            peak_nxt = acc_nxt;
            peak_at_nxt = bin_r;
          end
          acc_nxt = '0;
          k_nxt = '0;
          bin_nxt = bin_r + 1'b1;
        end else k_nxt = k_r + 1'b1;
        state_nxt = S_SM_RD;
      end
      S_SR_RD: begin
        state_nxt = ok_r ? S_SR_CMP : S_SH_END;
      end
      S_SR_CMP: begin
        if ({smooth_q, 16'd0} < lim_r) begin
          found_nxt = 1'b1;
          state_nxt = S_SH_END;
        end else if (bin_r == '0) state_nxt = S_SH_END;
        else begin
          bin_nxt = bin_r - 1'b1;
          state_nxt = S_SR_RD;
        end
      end
      S_SH_END: begin
        bin_nxt = '0;
        k_nxt = '0;
        acc_nxt = '0;
        peak_nxt = '0;
        peak_at_nxt = '0;
        if (ch_r == 2'd2) state_nxt = S_EMIT;
        else begin
          ch_nxt = ch_r + 1'b1;
          state_nxt = S_SM_RD;
        end
      end
      S_DV_GO: state_nxt = S_DV_WT;
      S_DV_WT: begin
        if (dv_done) begin
          if (ch_r == 2'd2) state_nxt = S_EMIT;
          else begin
            ch_nxt = ch_r + 1'b1;
            state_nxt = S_DV_GO;
          end
        end
      end
      S_EMIT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign shv = ({(BW+1)'(bin_r + 1'b1), 16'd0}) >> BW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      ch_r    <= '0;
      for (int c = 0; c < 3; c++) shift_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ch_r    <= ch_nxt;
      if (state_r == S_IDLE && start && in_op == hbps_pkg::OP_SHIFTS && !mode_r)
        for (int c = 0; c < 3; c++) shift_r[c] <= level_r[c];
      if (state_r == S_SH_END)
        shift_r[ch_r] <= found_r ? shv[15:0] : 16'd0;
    end
    out_valid_r <= rst_n && ov_nxt;
    bin_r     <= bin_nxt;
    peak_r    <= peak_nxt;
    peak_at_r <= peak_at_nxt;
    acc_r     <= acc_nxt;
    k_r       <= k_nxt;
    found_r   <= found_nxt;
    ok_r      <= ok_nxt;
    lim_r     <= PROD_W'(level_r[ch_r]) * PROD_W'(peak_r);
    if (state_r == S_IDLE && start) begin
      pix_r[0] <= in_red_in;
      pix_r[1] <= in_green_in;
      pix_r[2] <= in_blue_in;
      kind_r   <= (in_op == hbps_pkg::OP_SHIFTS);
    end
    if (state_r == S_DV_GO)
      res_r[ch_r] <= '0;
    if (state_r == S_DV_WT && dv_done && pix_r[ch_r] > cur_s)
      res_r[ch_r] <= (dv_q[31:16] != '0) ? 16'hFFFF : dv_q[15:0];
    if (state_r == S_EMIT && kind_r) begin
      res_r[0] <= mode_r ? shift_r[0] : level_r[0];
      res_r[1] <= mode_r ? shift_r[1] : level_r[1];
      res_r[2] <= mode_r ? shift_r[2] : level_r[2];
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r ? hbps_pkg::KIND_SHIFT : hbps_pkg::KIND_PIXEL;
  assign out_red_out   = res_r[0];
  assign out_green_out = res_r[1];
  assign out_blue_out  = res_r[2];

endmodule

// File: src/hbps_checker.sv
module hbps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat repeated");
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> busy) else $error("not busy after reset");
  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without command");

endmodule

bind histogram_black_point_stretch_core hbps_checker u_hbps_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid));

// File: tb/sv/histogram_black_point_stretch_core_tb.sv
module histogram_black_point_stretch_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS = hbps_pkg::BIN_COUNT;
  localparam int HALF = hbps_pkg::WINDOW / 2;
  localparam int CMAX = (1 << 24) - 1;
  localparam int LIMIT = 40000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] r, g, b;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] r, g, b;
  } res_t;

  logic clk = 0, rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_op = '0;
  logic [15:0] in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic out_valid, out_kind;
  logic [15:0] out_red_out, out_green_out, out_blue_out;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  histogram_black_point_stretch_core i_dut (.*);

  always #6 clk = ~clk;

  int unsigned hist [3][BINS];
  logic [15:0] shifts [3];
  logic [15:0] levels [3];
  logic rel_mode;

  cmd_t pending [$];
  res_t expected [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;

  task automatic report(input string what, input res_t got, input res_t want);
    $display("MISMATCH %s: got %0d %h %h %h want %0d %h %h %h", what,
             got.kind, got.r, got.g, got.b, want.kind, want.r, want.g, want.b);
    errors++;
  endtask

  function automatic logic [15:0] black_point(input int c, input logic [15:0] lvl);
    longint unsigned sm [BINS];
    longint unsigned peak;
    int at;
    peak = 0;
    at = 0;
    for (int i = 0; i < BINS; i++) begin
      sm[i] = 0;
      if (i >= HALF && i < BINS - HALF)
        for (int k = i - HALF; k <= i + HALF; k++) sm[i] += hist[c][k];
      if (sm[i] > peak) begin
        peak = sm[i];
        at = i;
      end
    end
    for (int i = at - 1; i >= 0; i--)
      if ((sm[i] << 16) < longint'(lvl) * peak)
        return 16'(((i + 1) << 16) / BINS);
    return 16'd0;
  endfunction

  function automatic logic [15:0] stretched(input logic [15:0] v, input logic [15:0] s);
    longint unsigned q;
    if (v <= s) return 16'd0;
    q = (longint'(v - s) << 16) / (65536 - longint'(s));
    return q > 65535 ? 16'hFFFF : 16'(q);
  endfunction

  function automatic void apply_cmd(input cmd_t c);
    logic [15:0] px [3];
    res_t r;
    int bin;
    px[0] = c.r; px[1] = c.g; px[2] = c.b;
    case (hbps_pkg::op_t'(c.op))
      hbps_pkg::OP_ACCUM: for (int k = 0; k < 3; k++) begin
        bin = (int'(px[k]) * BINS) >> 16;
        if (hist[k][bin] < CMAX) hist[k][bin]++;
      end
      hbps_pkg::OP_SHIFTS: begin
        for (int k = 0; k < 3; k++)
          shifts[k] = rel_mode ? black_point(k, levels[k]) : levels[k];
        r = '{hbps_pkg::KIND_SHIFT, shifts[0], shifts[1], shifts[2]};
        expected.push_back(r);
      end
      hbps_pkg::OP_STRETCH: begin
        for (int k = 0; k < 3; k++)
          px[k] = stretched(px[k], rel_mode ? shifts[k] : levels[k]);
        r = '{hbps_pkg::KIND_PIXEL, px[0], px[1], px[2]};
        expected.push_back(r);
      end
      default: for (int k = 0; k < 3; k++) for (int i = 0; i < BINS; i++) hist[k][i] = 0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        apply_cmd(cmd_t'({in_op, in_red_in, in_green_in, in_blue_in}));
        pending.pop_front();
      end
      if (start && busy) begin
      end else if (pending.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
        start <= 1;
        {in_op, in_red_in, in_green_in, in_blue_in} <= pending[0];
      end else
        start <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_valid) begin
      got = '{out_kind, out_red_out, out_green_out, out_blue_out};
      if (expected.size() == 0) report("unexpected beat", got, got);
      else if (got !== expected[0]) report("field", got, expected.pop_front());
      else void'(expected.pop_front());
    end
  end

  task automatic drain();
    while (pending.size() != 0 || start) @(posedge clk);
    while (expected.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(input hbps_pkg::reg_idx_t idx, input logic [15:0] d);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == hbps_pkg::REG_MODE) rel_mode = d[0];
    else levels[int'(idx) - 1] = d;
    cfg_valid <= 0;
  endtask

  task automatic set_all(input logic m, input logic [15:0] r, input logic [15:0] g,
                         input logic [15:0] b);
    drain();
    write_reg(hbps_pkg::REG_MODE, {15'd0, m});
    write_reg(hbps_pkg::REG_RED, r);
    write_reg(hbps_pkg::REG_GREEN, g);
    write_reg(hbps_pkg::REG_BLUE, b);
  endtask

  function automatic logic [15:0] rnd_pix();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(65535) & 16'hFF00);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push(input hbps_pkg::op_t op, input logic [15:0] r, input logic [15:0] g,
                      input logic [15:0] b);
    pending.push_back(cmd_t'({op, r, g, b}));
  endtask

  // a clustered frame followed by a shift computation and some stretches
  task automatic frame(input int n);
    logic [15:0] base [3];
    for (int k = 0; k < 3; k++) base[k] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        push(hbps_pkg::OP_ACCUM, rnd_pix(), rnd_pix(), rnd_pix());
      else push(hbps_pkg::OP_ACCUM, base[0] + 16'($urandom_range(4000)),
                base[1] + 16'($urandom_range(4000)), base[2] + 16'($urandom_range(4000)));
    end
    push(hbps_pkg::OP_SHIFTS, 16'($urandom), 16'($urandom), 16'($urandom));
    repeat ($urandom_range(3, 6))
      push(hbps_pkg::OP_STRETCH, rnd_pix(), rnd_pix(), rnd_pix());
    if ($urandom_range(3) == 0)
      push(hbps_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [15:0] lv [3];
    for (int k = 0; k < 3; k++) begin
      shifts[k] = 0;
      levels[k] = 0;
      for (int i = 0; i < BINS; i++) hist[k][i] = 0;
    end
    rel_mode = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed: unchanged pass before any shift, empty histogram, extremes
    push(hbps_pkg::OP_STRETCH, 16'h0000, 16'hFFFF, 16'h8000);
    push(hbps_pkg::OP_SHIFTS, 16'h0000, 16'h0000, 16'h0000);
    set_all(1'b1, 16'hFFFF, 16'h8000, 16'h0000);
    push(hbps_pkg::OP_STRETCH, 16'h1234, 16'hFFFF, 16'h0000);
    push(hbps_pkg::OP_SHIFTS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push(hbps_pkg::OP_ACCUM, 16'h0000, 16'hFFFF, 16'h8000);
    push(hbps_pkg::OP_ACCUM, 16'h00FF, 16'hFF00, 16'h7FFF);
    for (int i = 0; i < 8; i++) push(hbps_pkg::OP_ACCUM, 16'h4000, 16'h4100, 16'hC000);
    push(hbps_pkg::OP_SHIFTS, 16'h0000, 16'h0000, 16'h0000);
    push(hbps_pkg::OP_STRETCH, 16'hFFFF, 16'h4000, 16'h0001);
    push(hbps_pkg::OP_STRETCH, 16'h5555, 16'hAAAA, 16'hC000);
    push(hbps_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push(hbps_pkg::OP_SHIFTS, 16'h0000, 16'h0000, 16'h0000);
    set_all(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push(hbps_pkg::OP_SHIFTS, 16'h0000, 16'h0000, 16'h0000);
    push(hbps_pkg::OP_STRETCH, 16'hFFFF, 16'hFFFE, 16'h0000);
    push(hbps_pkg::OP_ACCUM, 16'h1111, 16'h2222, 16'h3333);
    set_all(1'b0, 16'h0000, 16'h0001, 16'h8000);
    push(hbps_pkg::OP_STRETCH, 16'h8001, 16'h0001, 16'h8000);

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      for (int k = 0; k < 3; k++)
        case ($urandom_range(3))
          0: lv[k] = 16'h0000;
          1: lv[k] = 16'hFFFF;
          default: lv[k] = 16'($urandom);
        endcase
      set_all(ph % 3 != 0, lv[0], lv[1], lv[2]);
      quiet = (ph == 4);
      while (pending.size() < 105) begin
        if ($urandom_range(4) == 0)
          push(hbps_pkg::op_t'($urandom_range(3)), rnd_pix(), rnd_pix(), rnd_pix());
        else frame($urandom_range(4, 30));
      end
    end
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: histogram_black_point_stretch_core.f
src/hbps_pkg.sv
src/hbps_div.sv
src/histogram_black_point_stretch_core.sv
src/hbps_checker.sv
tb/sv/histogram_black_point_stretch_core_tb.sv
